// ----- sv/hashed_key_value_table_assert.svh -----
// Assertion macros for the hashed key-value table.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef HASHED_KEY_VALUE_TABLE_ASSERT_SVH
`define HASHED_KEY_VALUE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKVT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hashed key-value table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HKVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hashed key-value table assertion failed");

`endif

// ----- sv/hkvt_pkg.sv -----
package hkvt_pkg;

  localparam int unsigned BUCKET_BITS_DEF = 5;
  localparam int unsigned WAYS_DEF        = 4;

  localparam logic [31:0] HASH_MULT = 32'h61C8_8647;

  localparam logic [1:0] REQ_PUT    = 2'd0;
  localparam logic [1:0] REQ_GET    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

endpackage

// ----- sv/hashed_key_value_table.sv -----
// Channel  | Valid / ready            | Payload
// request  | in_valid_i / in_ready_o  | req_type_i, key_i, value_i
// result   | out_valid_o / out_ready_i| ok_o, value_out_o, bucket_full_o, entry_count_o
//
// Accepts one request per cycle unless stalled; it passes the s1, s2 and output registers.
// The single read port of the bucket row memory is read once per request, and the
// previous cycle's row write is forwarded into the compare stage.
// Reset clears all slot valid bits and the entry count at once, with no clearing pass.
// A result held on the output with out_ready_i low freezes every stage and drops in_ready_o.
module hashed_key_value_table #(
  parameter int unsigned BucketBits = hkvt_pkg::BUCKET_BITS_DEF,
  parameter int unsigned Ways       = hkvt_pkg::WAYS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [31:0] key_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               ok_o,
  output logic signed [31:0] value_out_o,
  output logic               bucket_full_o,
  output logic [7:0]         entry_count_o
);
  import hkvt_pkg::*;

  localparam int unsigned Buckets = 1 << BucketBits;
  localparam int unsigned Slots   = Buckets * Ways;
  localparam int unsigned CntW    = ($clog2(Slots + 1) > 8) ? $clog2(Slots + 1) : 8;

  typedef entry_t [Ways-1:0] row_t;

  logic                  en;
  logic [31:0]           key_u;
  logic [31:0]           prod;

  logic                  s1_valid_q;
  logic [1:0]            s1_req_q;
  logic [31:0]           s1_key_q;
  logic [31:0]           s1_value_q;
  logic [BucketBits-1:0] s1_bucket_q;

  logic                  s2_valid_q;
  logic [1:0]            s2_req_q;
  logic [31:0]           s2_key_q;
  logic [31:0]           s2_value_q;
  logic [BucketBits-1:0] s2_bucket_q;
  row_t                  s2_row_q;

  logic                  lw_valid_q;
  logic [BucketBits-1:0] lw_bucket_q;
  row_t                  lw_row_q;

  row_t                  row_mem [Buckets];
  logic [Ways-1:0]       valid_q [Buckets];
  logic [CntW-1:0]       live_q;
  logic [CntW-1:0]       count_d;

  row_t                  row;
  row_t                  new_row;
  logic [Ways-1:0]       vrow;
  logic [Ways-1:0]       hit_oh;
  logic [Ways-1:0]       free_oh;
  logic                  found;
  logic                  has_free;
  logic [31:0]           hit_val;
  logic                  ok_d;
  logic [31:0]           vout_d;
  logic                  full_d;
  logic                  ins;
  logic                  del;

  logic                  out_valid_q;
  logic                  ok_q;
  logic [31:0]           vout_q;
  logic                  full_q;
  logic [7:0]            count_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  assign key_u = key_i;
  assign prod  = key_u * HASH_MULT;

  assign row  = (lw_valid_q && (lw_bucket_q == s2_bucket_q)) ? lw_row_q : s2_row_q;
  assign vrow = valid_q[s2_bucket_q];

  always_comb begin
    hit_oh   = '0;
    free_oh  = '0;
    found    = 1'b0;
    has_free = 1'b0;
    hit_val  = '0;
    for (int unsigned w = 0; w < Ways; w++) begin
      if (vrow[w]) begin
        if (!found && (row[w].key == s2_key_q)) begin
          found     = 1'b1;
          hit_oh[w] = 1'b1;
          hit_val   = row[w].value;
        end
      end else if (!has_free) begin
        has_free   = 1'b1;
        free_oh[w] = 1'b1;
      end
    end
  end

  always_comb begin
    ok_d   = 1'b0;
    vout_d = '0;
    full_d = 1'b0;
    ins    = 1'b0;
    del    = 1'b0;
    unique case (s2_req_q)
      REQ_PUT: begin
        if (found) begin
          vout_d = hit_val;
        end else if (!has_free) begin
          full_d = 1'b1;
        end else begin
          ok_d = 1'b1;
          ins  = s2_valid_q;
        end
      end
      REQ_GET: begin
        if (found) begin
          ok_d   = 1'b1;
          vout_d = hit_val;
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          ok_d   = 1'b1;
          vout_d = hit_val;
          del    = s2_valid_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int unsigned w = 0; w < Ways; w++) begin
      if (free_oh[w]) begin
        new_row[w].key   = s2_key_q;
        new_row[w].value = s2_value_q;
      end else begin
        new_row[w] = row[w];
      end
    end
  end

  always_comb begin
    count_d = live_q;
    if (ins) begin
      count_d = live_q + CntW'(1);
    end else if (del && (live_q != '0)) begin
      count_d = live_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lw_valid_q  <= 1'b0;
      live_q      <= '0;
      for (int unsigned b = 0; b < Buckets; b++) begin
        valid_q[b] <= '0;
      end
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
      lw_valid_q  <= ins;
      live_q      <= count_d;
      if (ins) begin
        valid_q[s2_bucket_q] <= vrow | free_oh;
      end else if (del) begin
        valid_q[s2_bucket_q] <= vrow & ~hit_oh;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_req_q    <= req_type_i;
      s1_key_q    <= key_u;
      s1_value_q  <= value_i;
      s1_bucket_q <= prod[31 -: BucketBits];
      s2_req_q    <= s1_req_q;
      s2_key_q    <= s1_key_q;
      s2_value_q  <= s1_value_q;
      s2_bucket_q <= s1_bucket_q;
      lw_bucket_q <= s2_bucket_q;
      lw_row_q    <= new_row;
      ok_q        <= ok_d;
      vout_q      <= vout_d;
      full_q      <= full_d;
      count_q     <= count_d[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && ins) begin
      row_mem[s2_bucket_q] <= new_row;
    end
    if (en) begin
      s2_row_q <= row_mem[s1_bucket_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign value_out_o   = vout_q;
  assign bucket_full_o = full_q;
  assign entry_count_o = count_q;

endmodule

// ----- sv/hkvt_checker.sv -----
`include "hashed_key_value_table_assert.svh"

module hkvt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               ok_o,
  input logic signed [31:0] value_out_o,
  input logic               bucket_full_o
);

  `HKVT_ASSERT_NEXT(a_stall_holds_valid, out_valid_o && !out_ready_i, out_valid_o)
  `HKVT_ASSERT_NEXT(a_stall_holds_value, out_valid_o && !out_ready_i, $stable(value_out_o))
  `HKVT_ASSERT_SAME(a_full_not_ok, out_valid_o && bucket_full_o, !ok_o)
  `HKVT_ASSERT_SAME(a_full_zero_value, out_valid_o && bucket_full_o, value_out_o == 32'sd0)

endmodule

bind hashed_key_value_table hkvt_checker u_hkvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .ok_o          (ok_o),
  .value_out_o   (value_out_o),
  .bucket_full_o (bucket_full_o)
);
